/* sv/y86_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// y86_pkg
// Shared types, codes and decode helpers of the Y86-64 instruction step core.
// ----------------------------------------------------------------------------
package y86_pkg;

  localparam int MEM_BYTES_DEF = 4096;

  localparam logic [1:0] ST_AOK = 2'd0;
  localparam logic [1:0] ST_HLT = 2'd1;
  localparam logic [1:0] ST_ADR = 2'd2;
  localparam logic [1:0] ST_INS = 2'd3;

  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_STEP = 2'd1;
  localparam logic [1:0] CMD_RREG = 2'd2;
  localparam logic [1:0] CMD_RMEM = 2'd3;

  localparam logic [3:0] I_HALT  = 4'h0;
  localparam logic [3:0] I_NOP   = 4'h1;
  localparam logic [3:0] I_CMOV  = 4'h2;
  localparam logic [3:0] I_IRMOV = 4'h3;
  localparam logic [3:0] I_RMMOV = 4'h4;
  localparam logic [3:0] I_MRMOV = 4'h5;
  localparam logic [3:0] I_ALU   = 4'h6;
  localparam logic [3:0] I_JXX   = 4'h7;
  localparam logic [3:0] I_CALL  = 4'h8;
  localparam logic [3:0] I_RET   = 4'h9;
  localparam logic [3:0] I_PUSH  = 4'hA;
  localparam logic [3:0] I_POP   = 4'hB;

  localparam logic [3:0] NOREG  = 4'hF;
  localparam logic [3:0] SP_REG = 4'h4;

  localparam logic [3:0] FN_ADD = 4'd0;
  localparam logic [3:0] FN_SUB = 4'd1;
  localparam logic [3:0] FN_AND = 4'd2;
  localparam logic [3:0] FN_XOR = 4'd3;
  localparam logic [3:0] FN_MAX = 4'd6;

  typedef enum logic [1:0] {A_NPC, A_M, A_IN, A_CLR} asel_t;
  typedef enum logic [1:0] {RS_RA, RS_B, RS_IDX} rsel_t;
  typedef enum logic [1:0] {BS_E, BS_B, BS_ADDR} bsel_t;
  typedef enum logic {WD_A, WD_NPC} wsel_t;
  typedef enum logic [1:0] {RV_ZERO, RV_A, RV_W} rvsel_t;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_LDB, S_RRA, S_RRW, S_RMEM,
    S_FOP, S_FOPW, S_DEC, S_FRR, S_FRRW, S_FIMM, S_FIMR, S_FIMW,
    S_CHK, S_RDA, S_RDB, S_RDBW, S_EXE, S_MEM, S_MRD, S_MRDW, S_MWR,
    S_WB, S_DONE
  } state_t;

  typedef struct packed {
    logic       in_ld;
    logic       clr_wr;
    logic       ld_byte;
    logic       rd_byte;
    logic       wr_byte;
    asel_t      asel;
    logic       npc_inc;
    logic       cnt_clr;
    logic       op_ld;
    logic       rr_ld;
    logic       imm_ld;
    logic       rf_rd;
    rsel_t      rsel;
    logic       cap_a;
    logic       cap_b;
    logic       ex;
    logic       base_ld;
    bsel_t      bsel;
    logic       wd_ld;
    wsel_t      wsel;
    logic       wd_clr;
    logic       sp_wr;
    logic       wb;
    logic       pc_upd;
    logic       resp;
    logic [1:0] status;
    rvsel_t     rv_sel;
  } cmd_t;

  typedef struct packed {
    logic       clr_last;
    logic       npc_oob;
    logic       npc_bad;
    logic       e_bad;
    logic       b_bad;
    logic       addr_bad;
    logic       e_neg;
    logic       cnt_last;
    logic       out_busy;
    logic [3:0] icode;
    logic [3:0] ifun;
    logic [3:0] ra;
    logic [3:0] rb;
  } sts_t;

  function automatic logic need_rr(input logic [3:0] icode);
    case (icode)
      I_CMOV, I_IRMOV, I_RMMOV, I_MRMOV, I_ALU, I_PUSH, I_POP: need_rr = 1'b1;
      default: need_rr = 1'b0;
    endcase
  endfunction

  function automatic logic need_imm(input logic [3:0] icode);
    case (icode)
      I_IRMOV, I_RMMOV, I_MRMOV, I_JXX, I_CALL: need_imm = 1'b1;
      default: need_imm = 1'b0;
    endcase
  endfunction

endpackage
`default_nettype wire

/* sv/y86_64_instruction_step_core.sv */
`default_nettype none
// Byte-wide memory port: a step fetches up to ten instruction bytes and
// moves up to eight data bytes, one per cycle. One request at a time;
// the next request is taken while the previous result waits in the output
// register. Reset: after rst_n the memory is cleared byte by byte before
// the first request is taken; registers, PC and flags reset at once.
// ----------------------------------------------------------------------------
// y86_64_instruction_step_core
// Y86-64 core with byte memory and register file, one command per request.
// ----------------------------------------------------------------------------
module y86_64_instruction_step_core #(
  parameter int MEM_BYTES = y86_pkg::MEM_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // command, address, load_byte, reg_index
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [87:0]      out_tdata   // status, pc_value, flags, read_value
);
  import y86_pkg::*;

  cmd_t        cmd;
  sts_t        sts;
  logic [1:0]  st;
  logic [11:0] pcv;
  logic [2:0]  fl;
  logic [63:0] rv;

  y86_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_command (in_tdata[1:0]),
    .sts        (sts),
    .cmd        (cmd)
  );

  y86_dp #(.MEM_BYTES(MEM_BYTES)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_address     (in_tdata[13:2]),
    .in_load_byte   (in_tdata[21:14]),
    .in_reg_index   (in_tdata[25:22]),
    .out_tready     (out_tready),
    .out_tvalid     (out_tvalid),
    .out_status     (st),
    .out_pc_value   (pcv),
    .out_flags      (fl),
    .out_read_value (rv)
  );

  assign out_tdata = {7'd0, rv, fl, pcv, st};

endmodule
`default_nettype wire

/* sv/y86_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// y86_ctrl
// Sequencer of the core: accepts requests, walks fetch, decode, register
// read, execute, memory and write-back phases and issues datapath commands.
// ----------------------------------------------------------------------------
module y86_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire logic [1:0]    in_command,
  input  wire y86_pkg::sts_t sts,
  output y86_pkg::cmd_t      cmd
);
  import y86_pkg::*;

  state_t     state_r, state_nxt;
  state_t     ret_r, ret_nxt;
  logic [1:0] st_r, st_nxt;
  logic [1:0] kind_r, kind_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      ret_r   <= S_DONE;
      st_r    <= ST_AOK;
      kind_r  <= CMD_LOAD;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      st_r    <= st_nxt;
      kind_r  <= kind_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    state_nxt = state_r;
    ret_nxt   = ret_r;
    st_nxt    = st_r;
    kind_nxt  = kind_r;
    case (state_r)
      S_CLR: begin
        cmd.clr_wr = 1'b1;
        cmd.asel   = A_CLR;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.in_ld = 1'b1;
          kind_nxt  = in_command;
          st_nxt    = ST_AOK;
          case (in_command)
            CMD_LOAD: state_nxt = S_LDB;
            CMD_STEP: state_nxt = S_FOP;
            CMD_RREG: state_nxt = S_RRA;
            default:  state_nxt = S_RMEM;
          endcase
        end
      end
      S_LDB: begin
        cmd.ld_byte = 1'b1;
        cmd.asel    = A_IN;
        state_nxt   = S_DONE;
      end
      S_RRA: begin
        cmd.rf_rd = 1'b1;
        cmd.rsel  = RS_IDX;
        state_nxt = S_RRW;
      end
      S_RRW: begin
        cmd.cap_a = 1'b1;
        state_nxt = S_DONE;
      end
      S_RMEM: begin
        if (sts.addr_bad) begin
          cmd.wd_clr = 1'b1;
          state_nxt  = S_DONE;
        end else begin
          cmd.base_ld = 1'b1;
          cmd.bsel    = BS_ADDR;
          ret_nxt     = S_DONE;
          state_nxt   = S_MRD;
        end
      end
      S_FOP: begin
        if (sts.npc_oob) begin
          st_nxt    = ST_ADR;
          state_nxt = S_DONE;
        end else begin
          cmd.rd_byte = 1'b1;
          cmd.asel    = A_NPC;
          cmd.npc_inc = 1'b1;
          state_nxt   = S_FOPW;
        end
      end
      S_FOPW: begin
        cmd.op_ld = 1'b1;
        state_nxt = S_DEC;
      end
      S_DEC: begin
        if (need_rr(sts.icode))       state_nxt = S_FRR;
        else if (need_imm(sts.icode)) state_nxt = S_FIMM;
        else                          state_nxt = S_CHK;
      end
      S_FRR: begin
        if (sts.npc_oob) begin
          st_nxt    = ST_ADR;
          state_nxt = S_DONE;
        end else begin
          cmd.rd_byte = 1'b1;
          cmd.asel    = A_NPC;
          cmd.npc_inc = 1'b1;
          state_nxt   = S_FRRW;
        end
      end
      S_FRRW: begin
        cmd.rr_ld = 1'b1;
        state_nxt = need_imm(sts.icode) ? S_FIMM : S_CHK;
      end
      S_FIMM: begin
        if (sts.npc_bad) begin
          st_nxt    = ST_ADR;
          state_nxt = S_DONE;
        end else begin
          cmd.cnt_clr = 1'b1;
          state_nxt   = S_FIMR;
        end
      end
      S_FIMR: begin
        cmd.rd_byte = 1'b1;
        cmd.asel    = A_NPC;
        cmd.npc_inc = 1'b1;
        if (sts.cnt_last) state_nxt = S_FIMW;
      end
      S_FIMW: begin
        state_nxt = S_CHK;
      end
      S_CHK: begin
        cmd.imm_ld = 1'b1;
        state_nxt  = S_RDA;
        if (sts.ifun > FN_MAX) begin
          st_nxt    = ST_INS;
          state_nxt = S_DONE;
        end else begin
          case (sts.icode)
            I_HALT: begin
              st_nxt    = ST_HLT;
              state_nxt = S_DONE;
            end
            I_NOP: begin
              cmd.pc_upd = 1'b1;
              state_nxt  = S_DONE;
            end
            I_IRMOV: begin
              if (sts.ra != NOREG) begin
                st_nxt    = ST_INS;
                state_nxt = S_DONE;
              end
            end
            I_RMMOV, I_MRMOV, I_CALL: begin
              if (sts.ifun != FN_ADD) begin
                st_nxt    = ST_INS;
                state_nxt = S_DONE;
              end
            end
            I_ALU: begin
              if (sts.ifun > FN_XOR) begin
                st_nxt    = ST_INS;
                state_nxt = S_DONE;
              end
            end
            I_CMOV, I_JXX, I_RET: begin
              state_nxt = S_RDA;
            end
            I_PUSH, I_POP: begin
              if (sts.rb != NOREG) begin
                cmd.pc_upd = 1'b1;
                state_nxt  = S_DONE;
              end
            end
            default: begin
              st_nxt    = ST_INS;
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_RDA: begin
        cmd.rf_rd = 1'b1;
        cmd.rsel  = RS_RA;
        state_nxt = S_RDB;
      end
      S_RDB: begin
        cmd.cap_a = 1'b1;
        cmd.rf_rd = 1'b1;
        cmd.rsel  = RS_B;
        state_nxt = S_RDBW;
      end
      S_RDBW: begin
        cmd.cap_b = 1'b1;
        state_nxt = S_EXE;
      end
      S_EXE: begin
        cmd.ex    = 1'b1;
        state_nxt = S_MEM;
      end
      S_MEM: begin
        state_nxt = S_WB;
        case (sts.icode)
          I_RMMOV: begin
            if (!sts.e_bad) begin
              cmd.base_ld = 1'b1;
              cmd.bsel    = BS_E;
              cmd.wd_ld   = 1'b1;
              cmd.wsel    = WD_A;
              ret_nxt     = S_WB;
              state_nxt   = S_MWR;
            end
          end
          I_MRMOV: begin
            if (sts.e_bad) begin
              st_nxt    = ST_ADR;
              state_nxt = S_DONE;
            end else begin
              cmd.base_ld = 1'b1;
              cmd.bsel    = BS_E;
              ret_nxt     = S_WB;
              state_nxt   = S_MRD;
            end
          end
          I_CALL, I_PUSH: begin
            if (sts.e_neg) begin
              st_nxt    = ST_ADR;
              state_nxt = S_DONE;
            end else begin
              cmd.sp_wr = 1'b1;
              if (!sts.e_bad) begin
                cmd.base_ld = 1'b1;
                cmd.bsel    = BS_E;
                cmd.wd_ld   = 1'b1;
                cmd.wsel    = (sts.icode == I_CALL) ? WD_NPC : WD_A;
                ret_nxt     = S_WB;
                state_nxt   = S_MWR;
              end
            end
          end
          I_RET, I_POP: begin
            cmd.sp_wr = 1'b1;
            if (sts.b_bad) begin
              cmd.wd_clr = 1'b1;
            end else begin
              cmd.base_ld = 1'b1;
              cmd.bsel    = BS_B;
              ret_nxt     = S_WB;
              state_nxt   = S_MRD;
            end
          end
          default: state_nxt = S_WB;
        endcase
      end
      S_MRD: begin
        cmd.rd_byte = 1'b1;
        cmd.asel    = A_M;
        if (sts.cnt_last) state_nxt = S_MRDW;
      end
      S_MRDW: begin
        state_nxt = ret_r;
      end
      S_MWR: begin
        cmd.wr_byte = 1'b1;
        cmd.asel    = A_M;
        if (sts.cnt_last) state_nxt = ret_r;
      end
      S_WB: begin
        cmd.wb     = 1'b1;
        cmd.pc_upd = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.resp   = 1'b1;
          cmd.status = st_r;
          case (kind_r)
            CMD_RREG: cmd.rv_sel = RV_A;
            CMD_RMEM: cmd.rv_sel = RV_W;
            default:  cmd.rv_sel = RV_ZERO;
          endcase
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

/* sv/y86_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// y86_dp
// Datapath of the core: byte memory, register file, PC, condition codes,
// ALU and address adder, word assembly and the result register.
// ----------------------------------------------------------------------------
module y86_dp #(
  parameter int MEM_BYTES = y86_pkg::MEM_BYTES_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire y86_pkg::cmd_t cmd,
  output y86_pkg::sts_t      sts,
  input  wire logic [11:0]   in_address,
  input  wire logic [7:0]    in_load_byte,
  input  wire logic [3:0]    in_reg_index,
  input  wire logic          out_tready,
  output logic               out_tvalid,
  output logic [1:0]         out_status,
  output logic [11:0]        out_pc_value,
  output logic [2:0]         out_flags,
  output logic [63:0]        out_read_value
);
  import y86_pkg::*;

  localparam int AW = $clog2(MEM_BYTES);
  localparam logic [63:0] MEM_SZ = 64'(MEM_BYTES);
  localparam logic [63:0] WLIM   = 64'(MEM_BYTES - 8);

  logic [7:0]    mem [MEM_BYTES];
  logic [63:0]   rf  [15];
  logic [14:0]   rf_vld_r;

  logic [63:0]   pc_r, npc_r, imm_r, vala_r, valb_r, vale_r, word_r;
  logic [2:0]    cc_r;
  logic [3:0]    icode_r, ifun_r, ra_r, rb_r;
  logic [11:0]   addr_r;
  logic [7:0]    byte_r, rdata_r;
  logic [3:0]    idx_r;
  logic [AW-1:0] maddr_r, clr_r;
  logic [2:0]    cnt_r;
  logic          rd_pend_r;
  logic [63:0]   rf_q_r;
  logic          rf_z_r;
  logic          out_valid_r;

  logic [63:0]   addr64;
  logic          in_ok;
  logic [AW-1:0] maddr;
  logic          mem_we;
  logic [7:0]    wdata;
  logic [3:0]    ridx, ri;
  logic          rok;
  logic          rf_we;
  logic [3:0]    widx;
  logic [63:0]   wval;
  logic          cond;
  logic          lt;
  logic [63:0]   e_val;
  logic          ovf;
  logic [63:0]   pc_next;

  assign addr64 = {52'd0, addr_r};
  assign in_ok  = addr64 < MEM_SZ;
  assign lt     = cc_r[1] ^ cc_r[0];

  always_comb begin
    case (ifun_r)
      4'd0:    cond = 1'b1;
      4'd1:    cond = lt | cc_r[2];
      4'd2:    cond = lt;
      4'd3:    cond = cc_r[2];
      4'd4:    cond = !cc_r[2];
      4'd5:    cond = !lt;
      4'd6:    cond = !lt && !cc_r[2];
      default: cond = 1'b0;
    endcase
  end

  always_comb begin
    case (cmd.asel)
      A_NPC:   maddr = npc_r[AW-1:0];
      A_M:     maddr = maddr_r + AW'(cnt_r);
      A_IN:    maddr = addr64[AW-1:0];
      default: maddr = clr_r;
    endcase
    mem_we = cmd.clr_wr | (cmd.ld_byte & in_ok) | cmd.wr_byte;
    if (cmd.ld_byte)      wdata = byte_r;
    else if (cmd.wr_byte) wdata = word_r[7:0];
    else                  wdata = 8'h00;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[maddr] <= wdata;
    rdata_r <= mem[maddr];
  end

  always_comb begin
    case (cmd.rsel)
      RS_RA:   ridx = ra_r;
      RS_B:    ridx = (icode_r == I_CALL || icode_r == I_RET || icode_r == I_PUSH ||
                       icode_r == I_POP) ? SP_REG : rb_r;
      default: ridx = idx_r;
    endcase
    rok = ridx != NOREG;
    ri  = rok ? ridx : 4'd0;
  end

  always_comb begin
    rf_we = 1'b0;
    widx  = SP_REG;
    wval  = vale_r;
    if (cmd.sp_wr) begin
      rf_we = 1'b1;
    end else if (cmd.wb) begin
      case (icode_r)
        I_CMOV: begin
          widx  = rb_r;
          wval  = vala_r;
          rf_we = cond;
        end
        I_IRMOV: begin
          widx  = rb_r;
          wval  = imm_r;
          rf_we = 1'b1;
        end
        I_MRMOV, I_POP: begin
          widx  = ra_r;
          wval  = word_r;
          rf_we = 1'b1;
        end
        I_ALU: begin
          widx  = rb_r;
          wval  = vale_r;
          rf_we = 1'b1;
        end
        default: rf_we = 1'b0;
      endcase
      if (widx == NOREG) rf_we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rf_we) rf[widx] <= wval;
    if (cmd.rf_rd) begin
      rf_q_r <= rf[ri];
      rf_z_r <= !rok || !rf_vld_r[ri];
    end
  end

  always_comb begin
    ovf   = 1'b0;
    e_val = valb_r + imm_r;
    case (icode_r)
      I_ALU: begin
        case (ifun_r)
          FN_ADD: begin
            e_val = vala_r + valb_r;
            ovf   = (vala_r[63] ^ e_val[63]) & (valb_r[63] ^ e_val[63]);
          end
          FN_SUB: begin
            e_val = valb_r - vala_r;
            ovf   = (vala_r[63] ^ valb_r[63]) & (valb_r[63] ^ e_val[63]);
          end
          FN_AND:  e_val = vala_r & valb_r;
          default: e_val = vala_r ^ valb_r;
        endcase
      end
      I_CALL, I_PUSH: e_val = valb_r - 64'd8;
      I_RET, I_POP:   e_val = valb_r + 64'd8;
      default:        e_val = valb_r + imm_r;
    endcase
  end

  always_comb begin
    case (icode_r)
      I_JXX:   pc_next = cond ? imm_r : npc_r;
      I_CALL:  pc_next = imm_r;
      I_RET:   pc_next = word_r;
      default: pc_next = npc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= 64'd0;
      cc_r        <= 3'b100;
      rf_vld_r    <= '0;
      clr_r       <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_pend_r <= cmd.rd_byte;
      if (cmd.clr_wr) clr_r <= clr_r + 1'b1;
      if (rf_we) rf_vld_r[widx] <= 1'b1;
      if (cmd.pc_upd) pc_r <= pc_next;
      if (cmd.ex && icode_r == I_ALU) cc_r <= {e_val == 64'd0, e_val[63], ovf};
      if (cmd.resp)      out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.in_ld) begin
      addr_r <= in_address;
      byte_r <= in_load_byte;
      idx_r  <= in_reg_index;
      npc_r  <= pc_r;
    end else if (cmd.npc_inc) begin
      npc_r <= npc_r + 64'd1;
    end
    if (cmd.cnt_clr || cmd.base_ld)      cnt_r <= 3'd0;
    else if (cmd.rd_byte || cmd.wr_byte) cnt_r <= cnt_r + 3'd1;
    if (cmd.base_ld) begin
      case (cmd.bsel)
        BS_E:    maddr_r <= vale_r[AW-1:0];
        BS_B:    maddr_r <= valb_r[AW-1:0];
        default: maddr_r <= addr64[AW-1:0];
      endcase
    end
    if (cmd.op_ld) begin
      icode_r <= rdata_r[7:4];
      ifun_r  <= rdata_r[3:0];
      ra_r    <= NOREG;
      rb_r    <= NOREG;
    end
    if (cmd.rr_ld) begin
      ra_r <= rdata_r[7:4];
      rb_r <= rdata_r[3:0];
    end
    if (cmd.imm_ld) imm_r <= word_r;
    if (cmd.cap_a)  vala_r <= rf_z_r ? 64'd0 : rf_q_r;
    if (cmd.cap_b)  valb_r <= rf_z_r ? 64'd0 : rf_q_r;
    if (cmd.ex)     vale_r <= e_val;
    if (cmd.wd_ld)        word_r <= (cmd.wsel == WD_NPC) ? npc_r : vala_r;
    else if (cmd.wd_clr)  word_r <= 64'd0;
    else if (cmd.wr_byte) word_r <= {8'h00, word_r[63:8]};
    else if (rd_pend_r)   word_r <= {rdata_r, word_r[63:8]};
    if (cmd.resp) begin
      out_status   <= cmd.status;
      out_pc_value <= pc_r[11:0];
      out_flags    <= cc_r;
      case (cmd.rv_sel)
        RV_A:    out_read_value <= vala_r;
        RV_W:    out_read_value <= word_r;
        default: out_read_value <= 64'd0;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;

  always_comb begin
    sts          = '0;
    sts.clr_last = clr_r == AW'(MEM_BYTES - 1);
    sts.npc_oob  = npc_r >= MEM_SZ;
    sts.npc_bad  = npc_r > WLIM;
    sts.e_bad    = vale_r > WLIM;
    sts.b_bad    = valb_r > WLIM;
    sts.addr_bad = addr64 > WLIM;
    sts.e_neg    = vale_r[63];
    sts.cnt_last = cnt_r == 3'd7;
    sts.out_busy = out_valid_r & ~out_tready;
    sts.icode    = icode_r;
    sts.ifun     = ifun_r;
    sts.ra       = ra_r;
    sts.rb       = rb_r;
  end

endmodule
`default_nettype wire

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Y86-64 instruction step core. Byte loads,
// instruction steps and register and memory reads go through a shadow core
// that computes the expected status, PC, flags and read value of each request.
// Both stream sides idle at random, but not while 400 to 649 requests are queued.
// ----------------------------------------------------------------------------
module tb_top;
  import y86_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] pc;
    logic [2:0]  flags;
    logic [63:0] rdval;
  } core_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [87:0] out_tdata;

  logic [31:0]  request_q[$];
  core_result_t result_q[$];
  int           mismatches;
  int           cycle_cnt;
  bit           stim_done;

  logic [7:0]  shadow_mem[4096];
  logic [63:0] shadow_rf[15];
  logic [63:0] shadow_pc;
  logic [2:0]  shadow_cc;

  y86_64_instruction_step_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic bit quiet_now();
    return request_q.size() >= 400 && request_q.size() < 650;
  endfunction

  function automatic logic [63:0] reg_get(input logic [3:0] id);
    return (id < 4'd15) ? shadow_rf[id] : 64'd0;
  endfunction

  function automatic void reg_put(input logic [3:0] id, input logic [63:0] v);
    if (id < 4'd15) shadow_rf[id] = v;
  endfunction

  function automatic bit word_ok(input logic [63:0] a);
    return a <= 64'd4088;
  endfunction

  function automatic logic [63:0] word_at(input logic [63:0] a);
    logic [63:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) r[8*i +: 8] = shadow_mem[12'(a + 64'(i))];
    return r;
  endfunction

  function automatic void word_put(input logic [63:0] a, input logic [63:0] v);
    if (word_ok(a))
      for (int i = 0; i < 8; i++) shadow_mem[12'(a + 64'(i))] = v[8*i +: 8];
  endfunction

  function automatic bit cond_ok(input logic [3:0] fn);
    logic z, lt;
    z  = shadow_cc[2];
    lt = shadow_cc[1] ^ shadow_cc[0];
    case (fn)
      4'd0: return 1'b1;
      4'd1: return lt | z;
      4'd2: return lt;
      4'd3: return z;
      4'd4: return !z;
      4'd5: return !lt;
      4'd6: return !lt && !z;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit stack_push(input logic [63:0] v);
    logic [63:0] sp;
    sp = shadow_rf[SP_REG] - 64'd8;
    if (sp[63]) return 1'b0;
    shadow_rf[SP_REG] = sp;
    word_put(sp, v);
    return 1'b1;
  endfunction

  function automatic logic [63:0] stack_pop();
    logic [63:0] sp;
    sp = shadow_rf[SP_REG];
    shadow_rf[SP_REG] = sp + 64'd8;
    return word_ok(sp) ? word_at(sp) : 64'd0;
  endfunction

  function automatic logic [1:0] shadow_exec();
    logic [63:0] npc, imm, a, b, r, v;
    logic [3:0]  ic, fn, ra, rb;
    logic        ovf;
    imm = '0;
    ra  = NOREG;
    rb  = NOREG;
    if (shadow_pc >= 64'd4096) return ST_ADR;
    {ic, fn} = shadow_mem[shadow_pc[11:0]];
    npc = shadow_pc + 64'd1;
    if ((ic >= I_CMOV && ic <= I_ALU) || ic == I_PUSH || ic == I_POP) begin
      if (npc >= 64'd4096) return ST_ADR;
      {ra, rb} = shadow_mem[npc[11:0]];
      npc++;
    end
    if (ic >= I_IRMOV && ic <= I_CALL && ic != I_ALU) begin
      if (!word_ok(npc)) return ST_ADR;
      imm = word_at(npc);
      npc += 64'd8;
    end
    if (fn > FN_MAX) return ST_INS;
    case (ic)
      I_HALT: return ST_HLT;
      I_NOP: ;
      I_CMOV: if (cond_ok(fn)) reg_put(rb, reg_get(ra));
      I_IRMOV: begin
        if (ra != NOREG) return ST_INS;
        reg_put(rb, imm);
      end
      I_RMMOV: begin
        if (fn != 4'd0) return ST_INS;
        word_put(reg_get(rb) + imm, reg_get(ra));
      end
      I_MRMOV: begin
        if (fn != 4'd0) return ST_INS;
        a = reg_get(rb) + imm;
        if (!word_ok(a)) return ST_ADR;
        reg_put(ra, word_at(a));
      end
      I_ALU: begin
        if (fn > FN_XOR) return ST_INS;
        a = reg_get(ra);
        b = reg_get(rb);
        ovf = 1'b0;
        case (fn)
          FN_ADD: begin
            r = a + b;
            ovf = (a[63] ^ r[63]) & (b[63] ^ r[63]);
          end
          FN_SUB: begin
            r = b - a;
            ovf = (a[63] ^ b[63]) & (b[63] ^ r[63]);
          end
          FN_AND: r = a & b;
          default: r = a ^ b;
        endcase
        reg_put(rb, r);
        shadow_cc = {r == 64'd0, r[63], ovf};
      end
      I_JXX: if (cond_ok(fn)) npc = imm;
      I_CALL: begin
        if (fn != 4'd0) return ST_INS;
        if (!stack_push(npc)) return ST_ADR;
        npc = imm;
      end
      I_RET: npc = stack_pop();
      I_PUSH: if (rb == NOREG && !stack_push(reg_get(ra))) return ST_ADR;
      I_POP: begin
        if (rb == NOREG) begin
          v = stack_pop();
          reg_put(ra, v);
        end
      end
      default: return ST_INS;
    endcase
    shadow_pc = npc;
    return ST_AOK;
  endfunction

  function automatic void send_request(input logic [1:0] cmd, input logic [11:0] addr,
                                       input logic [7:0] data, input logic [3:0] idx);
    core_result_t res;
    res = '0;
    case (cmd)
      CMD_LOAD: shadow_mem[addr] = data;
      CMD_STEP: res.status = shadow_exec();
      CMD_RREG: res.rdval = reg_get(idx);
      default:  res.rdval = word_ok({52'd0, addr}) ? word_at({52'd0, addr}) : 64'd0;
    endcase
    res.pc    = shadow_pc[11:0];
    res.flags = shadow_cc;
    request_q.push_back({6'd0, idx, data, addr, cmd});
    result_q.push_back(res);
  endfunction

  function automatic void place_and_step(input logic [3:0] ic, input logic [3:0] fn,
                                         input logic [3:0] ra, input logic [3:0] rb,
                                         input logic [63:0] imm);
    logic [63:0] p;
    bit          rr, im;
    p  = shadow_pc;
    rr = (ic >= I_CMOV && ic <= I_ALU) || ic == I_PUSH || ic == I_POP;
    im = ic >= I_IRMOV && ic <= I_CALL && ic != I_ALU;
    if (p < 64'd4096) send_request(CMD_LOAD, p[11:0], {ic, fn}, 4'($urandom_range(15)));
    p++;
    if (rr) begin
      if (p < 64'd4096) send_request(CMD_LOAD, p[11:0], {ra, rb}, 4'($urandom_range(15)));
      p++;
    end
    if (im)
      for (int i = 0; i < 8; i++)
        if (p + 64'(i) < 64'd4096)
          send_request(CMD_LOAD, 12'(p + 64'(i)), imm[8*i +: 8], 4'($urandom_range(15)));
    send_request(CMD_STEP, 12'($urandom), 8'($urandom), 4'($urandom));
  endfunction

  function automatic logic [63:0] pick_value();
    case ($urandom_range(5))
      0: return {$urandom, $urandom};
      1: return 64'h8000_0000_0000_0000;
      2: return 64'h7fff_ffff_ffff_ffff;
      3: return 64'hffff_ffff_ffff_ffff;
      default: return 64'($urandom_range(4095));
    endcase
  endfunction

  function automatic void random_step();
    logic [3:0]  ic, fn, ra, rb;
    logic [63:0] imm;
    ic  = ($urandom_range(19) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(11));
    if (ic == I_HALT && $urandom_range(3) != 0) ic = I_NOP;
    fn  = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'd0;
    if (ic == I_CMOV || ic == I_JXX) fn = ($urandom_range(9) == 0) ? 4'($urandom_range(15))
                                                                    : 4'($urandom_range(6));
    if (ic == I_ALU) fn = ($urandom_range(9) == 0) ? 4'($urandom_range(15))
                                                   : 4'($urandom_range(3));
    ra  = 4'($urandom_range(15));
    rb  = 4'($urandom_range(15));
    imm = pick_value();
    case (ic)
      I_IRMOV: begin
        if ($urandom_range(9) != 0) ra = NOREG;
        if ($urandom_range(2) == 0) begin
          rb  = SP_REG;
          imm = 64'($urandom_range(4000, 8));
        end
      end
      I_RMMOV, I_MRMOV: if ($urandom_range(3) != 0) imm = 64'($urandom_range(4088));
      I_JXX, I_CALL: imm = 64'($urandom_range(4000));
      I_PUSH, I_POP: if ($urandom_range(7) != 0) rb = NOREG;
      default: ;
    endcase
    place_and_step(ic, fn, ra, rb, imm);
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s: got %h, expected %h at cycle %0d", what, got, want, cycle_cnt);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      cycle_cnt <= 0;
    end else begin
      cycle_cnt <= cycle_cnt + 1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
    end else if (!in_tvalid || in_tready) begin
      if (request_q.size() != 0 && (quiet_now() || $urandom_range(99) >= 24)) begin
        in_tvalid <= 1'b1;
        in_tdata  <= request_q.pop_front();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    core_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (result_q.size() == 0) begin
          report_mismatch("unexpected result", out_tdata[63:0], 64'd0);
        end else begin
          want = result_q.pop_front();
          if (out_tdata[1:0] != want.status)
            report_mismatch("status", 64'(out_tdata[1:0]), 64'(want.status));
          if (out_tdata[13:2] != want.pc)
            report_mismatch("pc_value", 64'(out_tdata[13:2]), 64'(want.pc));
          if (out_tdata[16:14] != want.flags)
            report_mismatch("flags", 64'(out_tdata[16:14]), 64'(want.flags));
          if (out_tdata[80:17] != want.rdval)
            report_mismatch("read_value", out_tdata[80:17], want.rdval);
        end
      end
      out_tready <= quiet_now() || $urandom_range(99) >= 24;
    end
  end

  initial begin
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;
    mismatches = 0;
    cycle_cnt  = 0;
    stim_done  = 1'b0;
    rst_n      = 1'b0;
    foreach (shadow_mem[i]) shadow_mem[i] = 8'd0;
    foreach (shadow_rf[i]) shadow_rf[i] = 64'd0;
    shadow_pc = 64'd0;
    shadow_cc = 3'b100;

    send_request(CMD_RREG, 12'd0, 8'd0, 4'd15);
    send_request(CMD_LOAD, 12'd4095, 8'hff, 4'd0);
    send_request(CMD_RMEM, 12'd4088, 8'd0, 4'd0);
    send_request(CMD_RMEM, 12'd4089, 8'd0, 4'd0);
    send_request(CMD_STEP, 12'd0, 8'd0, 4'd0);
    place_and_step(I_IRMOV, 4'd0, NOREG, 4'd0, 64'h8000_0000_0000_0000);
    place_and_step(I_IRMOV, 4'd0, NOREG, 4'd1, 64'd1);
    place_and_step(I_ALU, FN_SUB, 4'd1, 4'd0, 64'd0);
    place_and_step(I_ALU, FN_ADD, 4'd0, 4'd0, 64'd0);
    place_and_step(I_CMOV, 4'd3, 4'd0, 4'd2, 64'd0);
    place_and_step(I_IRMOV, 4'd0, 4'd1, 4'd2, 64'd0);
    place_and_step(I_ALU, 4'd4, 4'd0, 4'd1, 64'd0);
    place_and_step(I_NOP, 4'd7, 4'd0, 4'd0, 64'd0);
    place_and_step(4'hC, 4'd0, 4'd0, 4'd0, 64'd0);
    place_and_step(I_CALL, 4'd0, 4'd0, 4'd0, 64'd200);
    place_and_step(I_PUSH, 4'd0, 4'd0, 4'd3, 64'd0);
    place_and_step(I_POP, 4'd0, SP_REG, NOREG, 64'd0);
    place_and_step(I_RET, 4'd0, 4'd0, 4'd0, 64'd0);
    place_and_step(I_MRMOV, 4'd0, 4'd3, NOREG, 64'd4090);
    place_and_step(I_RMMOV, 4'd1, 4'd3, NOREG, 64'd0);
    place_and_step(I_HALT, 4'd0, 4'd0, 4'd0, 64'd0);
    send_request(CMD_STEP, 12'd0, 8'd0, 4'd0);

    while (request_q.size() < 1000) begin
      case ($urandom_range(9))
        0: send_request(CMD_RREG, 12'($urandom), 8'($urandom), 4'($urandom));
        1: send_request(CMD_RMEM, 12'($urandom), 8'($urandom), 4'($urandom));
        2: send_request(CMD_LOAD, 12'($urandom), 8'($urandom), 4'($urandom));
        default: random_step();
      endcase
    end
    stim_done = 1'b1;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    while (request_q.size() != 0 || in_tvalid) @(posedge clk);
    while (result_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

/* files.f */
sv/y86_pkg.sv
sv/y86_ctrl.sv
sv/y86_dp.sv
sv/y86_64_instruction_step_core.sv
verif/tb_top.sv
